[sv/msqw_pkg.sv]
// package for the multi-server queue wait block
// payload structs, register map, reset values and controller/datapath bundles
// no dependencies
package msqw_pkg;

  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 17;
  localparam int MIN_W     = 8;
  localparam int NWIN_W    = 8;
  localparam int FREE_W    = 32;
  localparam int TOTAL_W   = 48;
  localparam int COUNT_W   = 32;
  localparam int WIDX_W    = 7;
  localparam int SVC_W     = 14;

  localparam logic [SVC_W-1:0]  SEC_PER_MIN  = SVC_W'(60);
  localparam logic [NWIN_W-1:0] NWIN_RESET   = NWIN_W'(1);
  localparam logic [TIME_W-1:0] OPEN_RESET   = TIME_W'(8 * 60 * 60);
  localparam logic [TIME_W-1:0] CLOSE_RESET  = TIME_W'(17 * 60 * 60);

  localparam logic [1:0] REG_NUM_WINDOWS = 2'd0;
  localparam logic [1:0] REG_OPEN_TIME   = 2'd1;
  localparam logic [1:0] REG_CLOSE_TIME  = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] arrival_seconds;
    logic [MIN_W-1:0]  service_minutes;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic [31:0]        wait_seconds;
    logic [WIDX_W-1:0]  window_index;
    logic [TOTAL_W-1:0] total_wait;
    logic [COUNT_W-1:0] served_count;
  } out_t;

  typedef struct packed {
    logic [NWIN_W-1:0] num_windows;
    logic [TIME_W-1:0] open_time;
    logic [TIME_W-1:0] close_time;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic clr_en;
    logic scan_en;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic refuse;
    logic clr_last;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

[sv/multi_server_queue_wait.sv]
// Multi-server FIFO queue waiting time. A start item (mode 0) refills every
// window's free time with open_time, clears the totals and answers with an all-zero
// result after a refill sweep over all MAX_WINDOWS entries. A customer arriving
// after close_time is refused without a scan. For an accepted customer the free
// times sit in one RAM and the search for the lowest-numbered earliest-free window
// reads it one entry per cycle over the n windows in use. After reset the block
// runs a clearing pass over all MAX_WINDOWS entries that loads 28800 into every
// window before the first input transfer is taken; configuration writes are taken
// at all times. One item is worked at a time; a finished result waits in the
// output register while the next item is taken. Depends on msqw_pkg, msqw_regs,
// msqw_ctrl, msqw_dp.
module multi_server_queue_wait #(
  parameter int MAX_WINDOWS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  msqw_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output msqw_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msqw_pkg::ADDR_W-1:0] paddr,
  input  logic [msqw_pkg::DATA_W-1:0] pwdata,
  output logic [msqw_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  msqw_pkg::cfg_t    cfg;
  msqw_pkg::cmd_t    cmd;
  msqw_pkg::status_t status;

  msqw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msqw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msqw_dp #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/msqw_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module msqw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/msqw_regs.sv]
// apb-style configuration registers: window count, opening and closing time
// depends on msqw_pkg
module msqw_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msqw_pkg::ADDR_W-1:0] paddr,
  input  logic [msqw_pkg::DATA_W-1:0] pwdata,
  output logic [msqw_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output msqw_pkg::cfg_t              cfg_o
);

  msqw_pkg::cfg_t cfg_q;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_windows <= msqw_pkg::NWIN_RESET;
      cfg_q.open_time   <= msqw_pkg::OPEN_RESET;
      cfg_q.close_time  <= msqw_pkg::CLOSE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        msqw_pkg::REG_NUM_WINDOWS: cfg_q.num_windows <= pwdata[msqw_pkg::NWIN_W-1:0];
        msqw_pkg::REG_OPEN_TIME:   cfg_q.open_time   <= pwdata[msqw_pkg::TIME_W-1:0];
        msqw_pkg::REG_CLOSE_TIME:  cfg_q.close_time  <= pwdata[msqw_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      msqw_pkg::REG_NUM_WINDOWS: prdata = msqw_pkg::DATA_W'(cfg_q.num_windows);
      msqw_pkg::REG_OPEN_TIME:   prdata = msqw_pkg::DATA_W'(cfg_q.open_time);
      msqw_pkg::REG_CLOSE_TIME:  prdata = msqw_pkg::DATA_W'(cfg_q.close_time);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[sv/msqw_ctrl.sv]
// controller state machine: reset clearing pass, session start sweep,
// earliest-window scan, window update and result hand-off; depends on msqw_pkg
module msqw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  msqw_pkg::status_t  status_i,
  output msqw_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] ST_CLEAR_RST = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_CLEAR     = 3'd2;
  localparam logic [2:0] ST_SCAN      = 3'd3;
  localparam logic [2:0] ST_UPDATE    = 3'd4;
  localparam logic [2:0] ST_RESULT    = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR_RST;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR_RST: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (status_i.is_start) begin
            state_d = ST_CLEAR;
          end else if (status_i.refuse) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/msqw_dp.sv]
// datapath: window free-time memory, scan for the earliest window, wait and
// total arithmetic, output register; depends on msqw_pkg and msqw_ram
module msqw_dp #(
  parameter int MAX_WINDOWS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msqw_pkg::cfg_t    cfg_i,
  input  msqw_pkg::in_t     in_data_i,
  input  msqw_pkg::cmd_t    cmd_i,
  output msqw_pkg::status_t status_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output msqw_pkg::out_t    out_data_o
);

  localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam int NW = (CW > msqw_pkg::NWIN_W) ? CW : msqw_pkg::NWIN_W;
  localparam int FW = msqw_pkg::FREE_W;
  localparam int TW = msqw_pkg::TOTAL_W;

  // item registers
  logic [msqw_pkg::TIME_W-1:0]  arrival_q;
  logic [msqw_pkg::MIN_W-1:0]   minutes_q;
  logic [msqw_pkg::TIME_W-1:0]  fill_time_q;

  // clearing sweep and scan control
  logic [AW-1:0] clr_cnt_q;
  logic [CW-1:0] scan_cnt_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic [FW-1:0] best_q;
  logic [AW-1:0] best_idx_q;

  // session totals and result
  logic [TW-1:0]                total_q;
  logic [msqw_pkg::COUNT_W-1:0] count_q;
  logic                         res_acc_q;
  logic [31:0]                  res_wait_q;
  logic [msqw_pkg::WIDX_W-1:0]  res_idx_q;
  logic                         out_valid_q;
  msqw_pkg::out_t               out_data_q;

  logic [NW-1:0]                nw_ext;
  logic [CW-1:0]                n_eff;
  logic                         rd_en;
  logic [FW-1:0]                rdata;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [FW-1:0]                ram_wdata;
  logic [FW-1:0]                arr_ext;
  logic [FW-1:0]                begin_t;
  logic [msqw_pkg::SVC_W-1:0]   svc_sec;
  logic [FW:0]                  next_sum;
  logic [FW-1:0]                next_free;
  logic [FW-1:0]                waited;
  logic [TW:0]                  total_sum;
  logic [TW-1:0]                total_next;
  logic [msqw_pkg::COUNT_W-1:0] count_next;

  always_comb begin
    nw_ext = NW'(cfg_i.num_windows);
    priority if (nw_ext == '0) begin
      n_eff = CW'(1);
    end else if (nw_ext > NW'(MAX_WINDOWS)) begin
      n_eff = CW'(MAX_WINDOWS);
    end else begin
      n_eff = CW'(nw_ext);
    end
  end

  assign rd_en = cmd_i.scan_en && (scan_cnt_q < n_eff);

  // update arithmetic
  assign arr_ext    = FW'(arrival_q);
  assign begin_t    = (arr_ext > best_q) ? arr_ext : best_q;
  assign svc_sec    = msqw_pkg::SVC_W'(minutes_q) * msqw_pkg::SEC_PER_MIN;
  assign next_sum   = {1'b0, begin_t} + (FW + 1)'(svc_sec);
  assign next_free  = next_sum[FW] ? '1 : next_sum[FW-1:0];
  assign waited     = begin_t - arr_ext;
  assign total_sum  = {1'b0, total_q} + (TW + 1)'(waited);
  assign total_next = total_sum[TW] ? '1 : total_sum[TW-1:0];
  assign count_next = (count_q == '1) ? count_q : count_q + 1'b1;

  assign ram_we    = cmd_i.clr_en || cmd_i.update;
  assign ram_waddr = cmd_i.clr_en ? clr_cnt_q : best_idx_q;
  assign ram_wdata = cmd_i.clr_en ? FW'(fill_time_q) : next_free;

  msqw_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_WINDOWS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (scan_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_time_q <= msqw_pkg::OPEN_RESET;
      clr_cnt_q   <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      total_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        scan_cnt_q <= '0;
        if (!in_data_i.mode) begin
          fill_time_q <= cfg_i.open_time;
          total_q     <= '0;
          count_q     <= '0;
        end
      end
      if (cmd_i.clr_en) begin
        clr_cnt_q <= status_o.clr_last ? '0 : clr_cnt_q + 1'b1;
      end
      if (rd_en) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      rd_vld_q <= rd_en;
      if (cmd_i.update) begin
        total_q <= total_next;
        count_q <= count_next;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      arrival_q  <= in_data_i.arrival_seconds;
      minutes_q  <= in_data_i.service_minutes;
      res_acc_q  <= 1'b0;
      res_wait_q <= '0;
      res_idx_q  <= '0;
    end
    if (rd_en) begin
      rd_idx_q <= scan_cnt_q[AW-1:0];
    end
    if (rd_vld_q && ((rd_idx_q == '0) || (rdata < best_q))) begin
      best_q     <= rdata;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.update) begin
      res_acc_q  <= 1'b1;
      res_wait_q <= waited;
      res_idx_q  <= msqw_pkg::WIDX_W'(best_idx_q);
    end
    if (cmd_i.load_out) begin
      out_data_q.accepted     <= res_acc_q;
      out_data_q.wait_seconds <= res_wait_q;
      out_data_q.window_index <= res_idx_q;
      out_data_q.total_wait   <= total_q;
      out_data_q.served_count <= count_q;
    end
  end

  assign status_o.is_start  = !in_data_i.mode;
  assign status_o.refuse    = in_data_i.arrival_seconds > cfg_i.close_time;
  assign status_o.clr_last  = (clr_cnt_q == AW'(MAX_WINDOWS - 1));
  assign status_o.scan_done = (scan_cnt_q == n_eff) && !rd_vld_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// testbench for multi_server_queue_wait: directed and random customer streams
// checked against an in-bench window scheduler; uses msqw_pkg and the block's rtl
module tb;

  localparam int MAX_WINDOWS = 128;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int TIME_W = msqw_pkg::TIME_W;
  localparam int MIN_W = msqw_pkg::MIN_W;
  localparam int NWIN_W = msqw_pkg::NWIN_W;
  localparam int FREE_W = msqw_pkg::FREE_W;
  localparam int TOTAL_W = msqw_pkg::TOTAL_W;
  localparam int COUNT_W = msqw_pkg::COUNT_W;
  localparam int WIDX_W = msqw_pkg::WIDX_W;
  localparam int ADDR_W = msqw_pkg::ADDR_W;
  localparam int DATA_W = msqw_pkg::DATA_W;
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_CUSTOMER = 1'b1;
  localparam logic [31:0] SECONDS_PER_MINUTE = 32'd60;
  localparam int ARRIVAL_MAX = (1 << TIME_W) - 1;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  msqw_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  msqw_pkg::out_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  multi_server_queue_wait #(.MAX_WINDOWS(MAX_WINDOWS)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // scheduler state mirrored in the bench
  logic [FREE_W-1:0] win_free [MAX_WINDOWS];
  logic [TOTAL_W-1:0] wait_sum;
  logic [COUNT_W-1:0] served_total;
  logic [NWIN_W-1:0] cfg_windows;
  logic [TIME_W-1:0] cfg_open;
  logic [TIME_W-1:0] cfg_close;

  msqw_pkg::out_t outcomes_due [$];
  msqw_pkg::out_t head_outcome;
  int errors;
  int items_sent;
  int cycles;
  bit idle_on;
  int hold_request;
  int hold_left;
  int stall_left;

  function automatic msqw_pkg::out_t queue_outcome(msqw_pkg::in_t item);
    msqw_pkg::out_t res;
    int unsigned n;
    int unsigned best;
    logic [FREE_W-1:0] start_at;
    logic [FREE_W-1:0] arrival;
    logic [FREE_W-1:0] waited;
    logic [FREE_W-1:0] svc_secs;
    logic [FREE_W:0] next_free;
    logic [TOTAL_W:0] sum;
    res = '0;
    if (item.mode == MODE_START) begin
      for (int i = 0; i < MAX_WINDOWS; i++) win_free[i] = FREE_W'(cfg_open);
      wait_sum = '0;
      served_total = '0;
      return res;
    end
    if (item.arrival_seconds > cfg_close) begin
      res.total_wait = wait_sum;
      res.served_count = served_total;
      return res;
    end
    n = 32'(cfg_windows);
    if (n == 0) n = 1;
    if (n > MAX_WINDOWS) n = MAX_WINDOWS;
    best = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (win_free[i] < win_free[best]) best = i;
    end
    arrival = FREE_W'(item.arrival_seconds);
    start_at = win_free[best];
    if (arrival > start_at) start_at = arrival;
    waited = start_at - arrival;
    svc_secs = FREE_W'(item.service_minutes) * SECONDS_PER_MINUTE;
    next_free = {1'b0, start_at} + {1'b0, svc_secs};
    win_free[best] = next_free[FREE_W] ? '1 : next_free[FREE_W-1:0];
    sum = {1'b0, wait_sum} + (TOTAL_W + 1)'(waited);
    wait_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    if (served_total != '1) served_total = served_total + 1'b1;
    res.accepted = 1'b1;
    res.wait_seconds = waited;
    res.window_index = best[WIDX_W-1:0];
    res.total_wait = wait_sum;
    res.served_count = served_total;
    return res;
  endfunction

  function automatic msqw_pkg::in_t customer_item(int arr, int svc);
    msqw_pkg::in_t item;
    item.mode = MODE_CUSTOMER;
    item.arrival_seconds = TIME_W'(arr);
    item.service_minutes = MIN_W'(svc);
    return item;
  endfunction

  function automatic msqw_pkg::in_t start_item();
    msqw_pkg::in_t item;
    item = '0;
    item.mode = MODE_START;
    item.arrival_seconds = TIME_W'($urandom);
    item.service_minutes = MIN_W'($urandom);
    return item;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("multi_server_queue_wait: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stall bursts plus long hold-offs on request
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(string field, logic [63:0] expected_v, logic [63:0] actual_v);
    $display("%0t: %s expected %0h actual %0h", $time, field, expected_v, actual_v);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, out_data_o);
        errors++;
      end else begin
        head_outcome = outcomes_due.pop_front();
        if (out_data_o.accepted !== head_outcome.accepted)
          flag_mismatch("accepted", 64'(head_outcome.accepted),
                        64'(out_data_o.accepted));
        if (out_data_o.wait_seconds !== head_outcome.wait_seconds)
          flag_mismatch("wait_seconds", 64'(head_outcome.wait_seconds),
                        64'(out_data_o.wait_seconds));
        if (out_data_o.window_index !== head_outcome.window_index)
          flag_mismatch("window_index", 64'(head_outcome.window_index),
                        64'(out_data_o.window_index));
        if (out_data_o.total_wait !== head_outcome.total_wait)
          flag_mismatch("total_wait", 64'(head_outcome.total_wait),
                        64'(out_data_o.total_wait));
        if (out_data_o.served_count !== head_outcome.served_count)
          flag_mismatch("served_count", 64'(head_outcome.served_count),
                        64'(out_data_o.served_count));
      end
    end
  end

  task automatic send_item(msqw_pkg::in_t item);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    outcomes_due.push_back(queue_outcome(item));
    items_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      msqw_pkg::REG_NUM_WINDOWS: cfg_windows = value[NWIN_W-1:0];
      msqw_pkg::REG_OPEN_TIME:   cfg_open = value[TIME_W-1:0];
      msqw_pkg::REG_CLOSE_TIME:  cfg_close = value[TIME_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_item(customer_item(0, 0));
    send_item(customer_item(61200, 255));
    send_item(customer_item(61201, 1));
    send_item(customer_item(ARRIVAL_MAX, 255));
    send_item(customer_item(30000, 0));
    send_item(start_item());
    send_item(customer_item(28800, 10));
    quiesce();
  endtask

  task automatic test_window_choice();
    idle_on = 1'b1;
    write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'd3);
    write_reg(msqw_pkg::REG_OPEN_TIME, 32'd0);
    write_reg(msqw_pkg::REG_CLOSE_TIME, 32'd86399);
    send_item(start_item());
    send_item(customer_item(0, 1));
    send_item(customer_item(0, 2));
    send_item(customer_item(0, 3));
    send_item(customer_item(0, 0));
    send_item(customer_item(200, 5));
    send_item(customer_item(5000, 7));
    send_item(customer_item(100, 4));
    quiesce();
    write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'd0);
    send_item(customer_item(6000, 2));
    quiesce();
    write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'd255);
    send_item(customer_item(6000, 2));
    send_item(customer_item(6000, 2));
    quiesce();
    // open time only lands at the next start
    write_reg(msqw_pkg::REG_OPEN_TIME, 32'd86399);
    send_item(customer_item(7000, 1));
    send_item(start_item());
    send_item(customer_item(0, 1));
    quiesce();
    write_reg(msqw_pkg::REG_OPEN_TIME, 32'(ARRIVAL_MAX));
    write_reg(msqw_pkg::REG_CLOSE_TIME, 32'd0);
    write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'd128);
    send_item(start_item());
    send_item(customer_item(0, 3));
    send_item(customer_item(1, 3));
    quiesce();
    write_reg(msqw_pkg::REG_CLOSE_TIME, 32'(ARRIVAL_MAX));
    send_item(customer_item(ARRIVAL_MAX, 255));
    quiesce();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'd2);
    write_reg(msqw_pkg::REG_OPEN_TIME, 32'd3600);
    write_reg(msqw_pkg::REG_CLOSE_TIME, 32'd86399);
    send_item(start_item());
    hold_request = 400;
    for (int i = 0; i < 40; i++) send_item(customer_item(3600 + 30 * i, $urandom_range(0, 255)));
    quiesce();
  endtask

  task automatic test_random_sessions(int budget, bit quiet);
    int stop_at;
    int sel;
    int arr;
    int step_hi;
    int seq_len;
    msqw_pkg::in_t noise;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'd0);
      else if (sel == 1) write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'($urandom_range(129, 255)));
      else if (sel <= 3) write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'($urandom_range(9, 128)));
      else write_reg(msqw_pkg::REG_NUM_WINDOWS, 32'($urandom_range(1, 8)));
      sel = $urandom_range(0, 9);
      if (sel == 0) write_reg(msqw_pkg::REG_OPEN_TIME, 32'd0);
      else if (sel == 1) write_reg(msqw_pkg::REG_OPEN_TIME, 32'd86399);
      else write_reg(msqw_pkg::REG_OPEN_TIME, 32'($urandom_range(0, 86399)));
      sel = $urandom_range(0, 9);
      if (sel == 0) write_reg(msqw_pkg::REG_CLOSE_TIME, 32'd86399);
      else if (sel == 1) write_reg(msqw_pkg::REG_CLOSE_TIME, 32'($urandom_range(0, ARRIVAL_MAX)));
      else write_reg(msqw_pkg::REG_CLOSE_TIME, 32'($urandom_range(cfg_open, 86399)));
      // sometimes keep the session going under the new settings
      if ($urandom_range(0, 2) != 0) send_item(start_item());
      arr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 86399) : int'(cfg_open);
      step_hi = ($urandom_range(0, 3) == 0) ? 3600 : 300;
      seq_len = $urandom_range(30, 100);
      for (int i = 0; i < seq_len; i++) begin
        sel = $urandom_range(0, 39);
        if (sel < 4) begin
          noise.mode = ($urandom_range(0, 3) == 0) ? MODE_START : MODE_CUSTOMER;
          noise.arrival_seconds = TIME_W'($urandom);
          noise.service_minutes = MIN_W'($urandom);
          send_item(noise);
        end else if (sel == 4) begin
          send_item(start_item());
        end else begin
          arr = arr + $urandom_range(0, step_hi);
          if (arr > ARRIVAL_MAX) arr = ARRIVAL_MAX;
          send_item(customer_item(arr, $urandom_range(0, 255)));
        end
      end
      quiesce();
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    idle_on = 1'b0;
    hold_request = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_windows = msqw_pkg::NWIN_RESET;
    cfg_open = msqw_pkg::OPEN_RESET;
    cfg_close = msqw_pkg::CLOSE_RESET;
    for (int i = 0; i < MAX_WINDOWS; i++) win_free[i] = FREE_W'(msqw_pkg::OPEN_RESET);
    wait_sum = '0;
    served_total = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_window_choice();
    test_backpressure();
    test_random_sessions(1100, 1'b0);
    test_random_sessions(60, 1'b1);

    quiesce();
    repeat (MAX_WINDOWS + 16) @(posedge clk_i);
    if (errors == 0) begin
      $display("multi_server_queue_wait: match");
    end else begin
      $display("multi_server_queue_wait: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
sv/msqw_pkg.sv
sv/msqw_ram.sv
sv/msqw_regs.sv
sv/msqw_ctrl.sv
sv/msqw_dp.sv
sv/multi_server_queue_wait.sv
sim/tb.sv
